### rtl/pfxc_pkg.sv
// Shared types and status codes for the pipe frame XOR checker.
package pfxc_pkg;

    // Verdict status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_PIPE      = 3'd1;
    localparam logic [2:0] ST_EMPTY_PREFIX = 3'd2;
    localparam logic [2:0] ST_NO_SECOND    = 3'd3;
    localparam logic [2:0] ST_BAD_HEX      = 3'd4;
    localparam logic [2:0] ST_MISMATCH     = 3'd5;
    localparam logic [2:0] ST_TOO_LONG     = 3'd6;

    // Classified byte handed from the front to the back
    typedef struct packed {
        logic       eol;     // CR or LF
        logic       pipe;    // '|'
        logic       space;   // 0x20
        logic       nib_ok;  // valid hex digit
        logic [3:0] nib;     // hex digit value
        logic [7:0] data;    // raw byte
    } class_t;

    // One line verdict
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
        logic [7:0] payload_length;
        logic [7:0] prefix_length;
    } verdict_t;

endpackage

### rtl/pfxc_fifo.sv
// Small register queue used between the front, the back and the result side.
module pfxc_fifo #(
    parameter type T     = logic [7:0],
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wr_data,
    output logic full,
    input  logic pop,
    output T     rd_data,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/pfxc_front.sv
// Front end: filters received bytes and classifies the ones that are kept.
module pfxc_front (
    input  logic              [7:0] rx_byte,
    input  logic                    push,
    input  logic                    cq_full,
    output logic                    full,
    output logic                    cq_push,
    output pfxc_pkg::class_t        item
);

    logic is_eol;
    logic printable;

    // Decode one hex digit in either case
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else
        begin
            r = 5'd0;
        end
        return r;
    endfunction

    assign is_eol    = (rx_byte == 8'h0D) || (rx_byte == 8'h0A);
    assign printable = (rx_byte >= 8'h20) && (rx_byte < 8'h7F);

    // Drop control and high bytes; pass line ends and printable bytes on
    assign full    = cq_full;
    assign cq_push = push && (is_eol || printable);

    // Classify the request
    always_comb
    begin
        item.eol                 = is_eol;
        item.pipe                = (rx_byte == 8'h7C);
        item.space               = (rx_byte == 8'h20);
        {item.nib_ok, item.nib}  = hex_nibble(rx_byte);
        item.data                = rx_byte;
    end

endmodule

### rtl/pfxc_back.sv
// Back end: tracks the line fields and builds a verdict at each line end.
module pfxc_back #(
    parameter int LINE_BUFFER_SIZE = 160
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pfxc_pkg::class_t        item,
    input  logic                    cq_empty,
    output logic                    cq_pop,
    input  logic                    rq_full,
    output logic                    rq_push,
    output pfxc_pkg::verdict_t      verdict
);

    localparam int CW = $clog2(LINE_BUFFER_SIZE);
    localparam int SW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] LINE_LIMIT = CW'(LINE_BUFFER_SIZE - 1);

    // Field phase codes
    localparam logic [1:0] PH_PREFIX   = 2'd0;
    localparam logic [1:0] PH_PAYLOAD  = 2'd1;
    localparam logic [1:0] PH_CHECKSUM = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] line_reg, line_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] pre_reg, pre_next;
    logic [CW-1:0] pay_reg, pay_next;
    logic [7:0]    xor_reg, xor_next;
    logic [1:0]    hcnt_reg, hcnt_next;
    logic [7:0]    hval_reg, hval_next;
    logic          hbad_reg, hbad_next;
    logic          tsp_reg, tsp_next;
    logic          fire;

    // Clamp a count to the 8-bit result field
    function automatic logic [7:0] sat8(input logic [CW-1:0] v);
        logic [SW-1:0] w;
        w = SW'(v);
        return (w > SW'(255)) ? 8'hFF : w[7:0];
    endfunction

    assign fire   = !cq_empty && !rq_full;
    assign cq_pop = fire;

    // Update line state and build the verdict
    always_comb
    begin
        phase_next = phase_reg;
        line_next  = line_reg;
        ovf_next   = ovf_reg;
        pre_next   = pre_reg;
        pay_next   = pay_reg;
        xor_next   = xor_reg;
        hcnt_next  = hcnt_reg;
        hval_next  = hval_reg;
        hbad_next  = hbad_reg;
        tsp_next   = tsp_reg;
        rq_push    = 1'b0;
        verdict    = '0;

        if (fire && item.eol)
        begin
            // Judge the line, unless it is empty
            priority if (ovf_reg)
            begin
                verdict.status = pfxc_pkg::ST_TOO_LONG;
                rq_push        = 1'b1;
            end
            else if (line_reg == '0)
            begin
                rq_push = 1'b0;
            end
            else if (phase_reg == PH_PREFIX)
            begin
                verdict.status = pfxc_pkg::ST_NO_PIPE;
                rq_push        = 1'b1;
            end
            else if (pre_reg == '0)
            begin
                verdict.status = pfxc_pkg::ST_EMPTY_PREFIX;
                rq_push        = 1'b1;
            end
            else if (phase_reg == PH_PAYLOAD)
            begin
                verdict.status        = pfxc_pkg::ST_NO_SECOND;
                verdict.prefix_length = sat8(pre_reg);
                rq_push               = 1'b1;
            end
            else
            begin
                verdict.prefix_length     = sat8(pre_reg);
                verdict.payload_length    = sat8(pay_reg);
                verdict.computed_checksum = xor_reg;
                rq_push                   = 1'b1;
                if (hbad_reg || hcnt_reg != 2'd2)
                begin
                    verdict.status = pfxc_pkg::ST_BAD_HEX;
                end
                else
                begin
                    verdict.received_checksum = hval_reg;
                    verdict.status = (xor_reg == hval_reg) ? pfxc_pkg::ST_OK
                                                           : pfxc_pkg::ST_MISMATCH;
                end
            end
            // Clear the line
            phase_next = PH_PREFIX;
            line_next  = '0;
            ovf_next   = 1'b0;
            pre_next   = '0;
            pay_next   = '0;
            xor_next   = '0;
            hcnt_next  = '0;
            hval_next  = '0;
            hbad_next  = 1'b0;
            tsp_next   = 1'b0;
        end
        else if (fire)
        begin
            if (line_reg < LINE_LIMIT)
            begin
                line_next = line_reg + 1'b1;
                unique case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (item.pipe)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            pre_next = pre_reg + 1'b1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (item.pipe)
                        begin
                            phase_next = PH_CHECKSUM;
                        end
                        else
                        begin
                            pay_next = pay_reg + 1'b1;
                            xor_next = xor_reg ^ item.data;
                        end
                    end
                    default:
                    begin
                        // Checksum text: two hex digits, then only spaces
                        priority if (item.space)
                        begin
                            tsp_next = 1'b1;
                        end
                        else if (tsp_reg || !item.nib_ok || hcnt_reg >= 2'd2)
                        begin
                            hbad_next = 1'b1;
                        end
                        else
                        begin
                            hval_next = {hval_reg[3:0], item.nib};
                            hcnt_next = hcnt_reg + 1'b1;
                        end
                    end
                endcase
            end
            else
            begin
                // Line full: drop the byte and mark the overflow
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            line_reg  <= '0;
            ovf_reg   <= 1'b0;
            pre_reg   <= '0;
            pay_reg   <= '0;
            xor_reg   <= '0;
            hcnt_reg  <= '0;
            hval_reg  <= '0;
            hbad_reg  <= 1'b0;
            tsp_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            ovf_reg   <= ovf_next;
            pre_reg   <= pre_next;
            pay_reg   <= pay_next;
            xor_reg   <= xor_next;
            hcnt_reg  <= hcnt_next;
            hval_reg  <= hval_next;
            hbad_reg  <= hbad_next;
            tsp_reg   <= tsp_next;
        end
    end

endmodule

### rtl/pipe_frame_xor_checker_core.sv
// Top level of the pipe frame XOR checker: front, byte queue, back, result queue.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | rx_byte
//  result   | empty / pop        | status, computed_checksum,
//           |                    | received_checksum, payload_length,
//           |                    | prefix_length
//
// One byte is taken every cycle while full is low; the back end retires one
// queued byte per cycle while the byte queue is not empty and the result queue
// is not full. A line end's verdict is shown once it heads the result queue.
// Reset is asynchronous, active low, and clears both queues and the line state.
// Holding pop low stalls the back end once the result queue fills; the byte queue
// then fills and full rises.
module pipe_frame_xor_checker_core #(
    parameter int LINE_BUFFER_SIZE = 160
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] status,
    output logic [7:0] computed_checksum,
    output logic [7:0] received_checksum,
    output logic [7:0] payload_length,
    output logic [7:0] prefix_length
);

    pfxc_pkg::class_t   fe_item, cq_item;
    pfxc_pkg::verdict_t be_verdict, rq_head;
    logic               cq_push, cq_full, cq_pop, cq_empty;
    logic               rq_push, rq_full;

    // Classify incoming bytes
    pfxc_front u_front (
        .rx_byte (rx_byte),
        .push    (push),
        .cq_full (cq_full),
        .full    (full),
        .cq_push (cq_push),
        .item    (fe_item)
    );

    // Hold classified bytes between front and back
    pfxc_fifo #(
        .T (pfxc_pkg::class_t)
    ) u_byte_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cq_push),
        .wr_data (fe_item),
        .full    (cq_full),
        .pop     (cq_pop),
        .rd_data (cq_item),
        .empty   (cq_empty)
    );

    // Track fields and judge lines
    pfxc_back #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (cq_item),
        .cq_empty (cq_empty),
        .cq_pop   (cq_pop),
        .rq_full  (rq_full),
        .rq_push  (rq_push),
        .verdict  (be_verdict)
    );

    // Hold verdicts until taken
    pfxc_fifo #(
        .T (pfxc_pkg::verdict_t)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rq_push),
        .wr_data (be_verdict),
        .full    (rq_full),
        .pop     (pop),
        .rd_data (rq_head),
        .empty   (empty)
    );

    assign status            = rq_head.status;
    assign computed_checksum = rq_head.computed_checksum;
    assign received_checksum = rq_head.received_checksum;
    assign payload_length    = rq_head.payload_length;
    assign prefix_length     = rq_head.prefix_length;

    // Never write a verdict into a full result queue
    a_rq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |-> !rq_full)
        else $error("verdict pushed into full result queue");

    // Never retire a byte from an empty byte queue
    a_cq_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        cq_pop |-> !cq_empty)
        else $error("byte retired from empty queue");

    // An ok verdict carries matching checksums
    a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == pfxc_pkg::ST_OK) |-> (computed_checksum == received_checksum))
        else $error("ok verdict with differing checksums");

    // Early failures carry no lengths or checksums
    a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == pfxc_pkg::ST_NO_PIPE || status == pfxc_pkg::ST_EMPTY_PREFIX
                    || status == pfxc_pkg::ST_TOO_LONG))
        |-> (prefix_length == 8'd0 && payload_length == 8'd0 && computed_checksum == 8'd0))
        else $error("early failure verdict carries field data");

endmodule

### dv/testbench.sv
// Self-checking testbench for the pipe frame XOR checker core.
module testbench;

    localparam int LINE_BUF_BYTES = 160;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT        = 3000000;

    // Byte codes that steer the line parser
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [1:0] {PH_PREFIX, PH_PAYLOAD, PH_CHECKSUM} phase_t;

    // Shapes of checksum text the frame builder can produce
    typedef enum int {
        CK_GOOD, CK_WRONG, CK_TRAIL, CK_ONE, CK_THREE,
        CK_LEAD, CK_NONHEX, CK_PIPE, CK_SPLIT
    } ck_kind_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] rx_byte;
    logic       empty;
    logic       pop;
    logic [2:0] status;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [7:0] payload_length;
    logic [7:0] prefix_length;

    // Line state of the verdict predictor
    phase_t     phase;
    int         stored_cnt;
    bit         overflow;
    int         pre_cnt;
    int         pay_cnt;
    logic [7:0] xor_acc;
    int         hex_cnt;
    logic [7:0] hex_val;
    bit         hex_bad;
    bit         space_seen;

    pfxc_pkg::verdict_t verdict_q[$];
    int         mismatch_count;
    int         bytes_sent;
    int         burst_left;
    bit         pacing_on;
    bit         hold_req;

    pipe_frame_xor_checker_core #(
        .LINE_BUFFER_SIZE(LINE_BUF_BYTES)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .rx_byte           (rx_byte),
        .empty             (empty),
        .pop               (pop),
        .status            (status),
        .computed_checksum (computed_checksum),
        .received_checksum (received_checksum),
        .payload_length    (payload_length),
        .prefix_length     (prefix_length)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Return the line state to its idle values
    function automatic void reset_line_state();
        phase      = PH_PREFIX;
        stored_cnt = 0;
        overflow   = 1'b0;
        pre_cnt    = 0;
        pay_cnt    = 0;
        xor_acc    = 8'h00;
        hex_cnt    = 0;
        hex_val    = 8'h00;
        hex_bad    = 1'b0;
        space_seen = 1'b0;
    endfunction

    // Advance the predictor by one byte; return 1 when a verdict is due
    function automatic bit frame_step(input logic [7:0] c, output pfxc_pkg::verdict_t v);
        int nib;
        v = '0;
        if (c != CH_CR && c != CH_LF) begin
            if (c < CH_SPACE || c >= CH_DEL)
                return 1'b0;
            if (stored_cnt < LINE_BUF_BYTES - 1) begin
                stored_cnt++;
                case (phase)
                    PH_PREFIX:
                    begin
                        if (c == CH_PIPE) phase = PH_PAYLOAD;
                        else pre_cnt++;
                    end
                    PH_PAYLOAD:
                    begin
                        if (c == CH_PIPE) begin
                            phase = PH_CHECKSUM;
                        end else begin
                            pay_cnt++;
                            xor_acc ^= c;
                        end
                    end
                    default:
                    begin
                        if (c >= "0" && c <= "9")      nib = c - "0";
                        else if (c >= "A" && c <= "F") nib = c - "A" + 10;
                        else if (c >= "a" && c <= "f") nib = c - "a" + 10;
                        else                           nib = 16;
                        if (c == CH_SPACE) begin
                            space_seen = 1'b1;
                        end else if (space_seen || nib > 15 || hex_cnt >= 2) begin
                            hex_bad = 1'b1;
                        end else begin
                            hex_val = {hex_val[3:0], 4'(nib)};
                            hex_cnt++;
                        end
                    end
                endcase
            end else begin
                overflow = 1'b1;
            end
            return 1'b0;
        end

        // Line end: form the verdict
        if (overflow) begin
            v.status = pfxc_pkg::ST_TOO_LONG;
        end else if (stored_cnt == 0) begin
            reset_line_state();
            return 1'b0;
        end else if (phase == PH_PREFIX) begin
            v.status = pfxc_pkg::ST_NO_PIPE;
        end else if (pre_cnt == 0) begin
            v.status = pfxc_pkg::ST_EMPTY_PREFIX;
        end else if (phase == PH_PAYLOAD) begin
            v.status        = pfxc_pkg::ST_NO_SECOND;
            v.prefix_length = 8'(pre_cnt);
        end else begin
            v.prefix_length     = 8'(pre_cnt);
            v.payload_length    = 8'(pay_cnt);
            v.computed_checksum = xor_acc;
            if (hex_bad || hex_cnt != 2) begin
                v.status = pfxc_pkg::ST_BAD_HEX;
            end else begin
                v.received_checksum = hex_val;
                v.status = (xor_acc == hex_val) ? pfxc_pkg::ST_OK : pfxc_pkg::ST_MISMATCH;
            end
        end
        reset_line_state();
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit up);
        if (n < 10)
            return 8'(8'h30 + n);
        return 8'((up ? 8'h41 : 8'h61) + n - 10);
    endfunction

    // Printable byte that is not a pipe
    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(32, 126)); while (b == CH_PIPE);
        return b;
    endfunction

    // Offer one request, hold it until taken, then predict and pace
    task automatic send_byte(input logic [7:0] b);
        pfxc_pkg::verdict_t v;
        int gap;
        push    <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full);
        bytes_sent++;
        if (frame_step(b, v))
            verdict_q.push_back(v);
        if (pacing_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(0, 8);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
            end
        end
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
    endtask

    // Send a byte, sometimes after a byte the parser must drop
    task automatic send_noisy(input logic [7:0] b, input int noise_pct);
        logic [7:0] junk;
        if ($urandom_range(0, 99) < noise_pct) begin
            case ($urandom_range(0, 2))
                0:
                begin
                    junk = 8'($urandom_range(0, 31));
                    if (junk == CH_CR || junk == CH_LF) junk = 8'h00;
                end
                1:       junk = CH_DEL;
                default: junk = 8'($urandom_range(128, 255));
            endcase
            send_byte(junk);
        end
        send_byte(b);
    endtask

    // Build one line: prefix, pipes, payload, checksum text, line end
    task automatic send_frame(input int pre_len, input int pay_len, input int pipes,
                              input ck_kind_t ck, input int noise_pct);
        logic [7:0] b;
        logic [7:0] sum;
        bit         up;
        sum = 8'h00;
        up  = 1'($urandom_range(0, 1));
        for (int i = 0; i < pre_len; i++)
            send_noisy(rand_text_byte(), noise_pct);
        if (pipes >= 1)
            send_noisy(CH_PIPE, noise_pct);
        for (int i = 0; i < pay_len; i++) begin
            b = rand_text_byte();
            sum ^= b;
            send_noisy(b, noise_pct);
        end
        if (pipes >= 2) begin
            send_noisy(CH_PIPE, noise_pct);
            if (ck == CK_WRONG)
                sum ^= 8'($urandom_range(1, 255));
            if (ck == CK_LEAD)
                send_byte(CH_SPACE);
            if (ck == CK_NONHEX) begin
                send_byte(hex_char(sum[7:4], up));
                send_byte("g");
            end else if (ck == CK_SPLIT) begin
                send_byte(hex_char(sum[7:4], up));
                send_byte(CH_SPACE);
                send_byte(hex_char(sum[3:0], up));
            end else begin
                send_byte(hex_char(sum[7:4], up));
                if (ck != CK_ONE)
                    send_byte(hex_char(sum[3:0], up));
            end
            if (ck == CK_THREE)
                send_byte(hex_char(4'($urandom_range(0, 15)), up));
            if (ck == CK_PIPE)
                send_byte(CH_PIPE);
            if (ck == CK_TRAIL)
                repeat ($urandom_range(1, 3))
                    send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
        case ($urandom_range(0, 9))
            0:
            begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            1, 2, 3, 4: send_byte(CH_CR);
            default:    send_byte(CH_LF);
        endcase
    endtask

    // The no-pipe, empty-prefix, no-second, ok and mismatch codes, the empty line and a line of spaces
    task automatic test_status_codes();
        send_text("\n");
        send_text("~\r");
        send_text(" \n");
        send_text("|\n");
        send_text("!|\n");
        send_text("a||00\n");
        send_text("a|~|7e\n");
        send_text("a| |21\n");
    endtask

    // Checksum text: case, trailing blanks, and each way to spoil it
    task automatic test_checksum_text();
        send_text("k|AZ|1B\r\n");
        send_text("k|AZ|1b  \n");
        send_text("k|AZ|1b\t \t\n");
        send_text("k|AZ| 1b\n");
        send_text("k|AZ|1 b\n");
        send_text("k|AZ|1\n");
        send_text("k|AZ|1b1\n");
        send_text("k|AZ|1g\n");
        send_text("k|AZ|1b|\n");
        send_text("k|AZ|  \n");
        send_text("k|AZ|ff\n");
        send_text("k|AZ|\n");
    endtask

    // Control bytes, DEL and high bytes vanish from the line
    task automatic test_dropped_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(CH_DEL);
        send_byte(8'h1F);
        send_byte(CH_LF);
        send_byte("z");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_CR);
        repeat (4) send_frame(3, 5, 2, CK_GOOD, 60);
    endtask

    // Lines at and beyond the stored length limit
    task automatic test_line_limit();
        send_frame(1, 154, 2, CK_GOOD, 0);
        send_frame(1, 155, 2, CK_GOOD, 0);
        send_frame(157, 1, 1, CK_GOOD, 0);
        send_frame(0, 155, 2, CK_GOOD, 0);
        send_frame(LINE_BUF_BYTES, 0, 0, CK_GOOD, 0);
    endtask

    // Mostly well-formed frames with random content, some noise lines
    task automatic test_random_frames(input int budget);
        int target;
        int r;
        int k;
        int pre_len;
        int pay_len;
        ck_kind_t ck;
        target = bytes_sent + budget;
        while (bytes_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom_range(0, 255)));
                send_byte(CH_LF);
            end else begin
                pre_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                pay_len = ($urandom_range(0, 49) == 0) ? $urandom_range(140, 160)
                                                       : $urandom_range(0, 12);
                k = $urandom_range(0, 99);
                if (k < 65)      ck = CK_GOOD;
                else if (k < 75) ck = CK_WRONG;
                else if (k < 83) ck = CK_TRAIL;
                else             ck = ck_kind_t'($urandom_range(CK_ONE, CK_SPLIT));
                send_frame(pre_len, pay_len, (r < 9) ? 0 : (r < 12) ? 1 : 2, ck, 4);
            end
        end
    endtask

    // Hold the result side off while requests keep coming, so full rises
    task automatic test_back_pressure();
        pacing_on = 1'b0;
        hold_req  = 1'b1;
        repeat (30) send_frame(1, 1, 2, CK_GOOD, 0);
        pacing_on = 1'b1;
    endtask

    // Compare one verdict field
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Check every verdict taken from the result side against the oldest prediction
    always @(posedge clk)
    begin : verdict_check
        pfxc_pkg::verdict_t want;
        if (rst_n && pop && !empty) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict expected none actual status %0d", $time, status);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                check_field("status", 8'(want.status), 8'(status));
                check_field("computed_checksum", want.computed_checksum, computed_checksum);
                check_field("received_checksum", want.received_checksum, received_checksum);
                check_field("payload_length", want.payload_length, payload_length);
                check_field("prefix_length", want.prefix_length, prefix_length);
            end
        end
    end

    // Drive pop: changing stall modes, plus a long hold-off on request
    initial
    begin : result_drain
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        pop       = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req && hold_left == 0) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 9) != 0);
                    default: pop <= ((mode_left % 16) < 11);
                endcase
            end
        end
    end

    // Guard against a hang
    initial
    begin : watchdog
        #(TIMEOUT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : main_sequence
        rst_n          = 1'b0;
        push           = 1'b0;
        rx_byte        = 8'h00;
        hold_req       = 1'b0;
        pacing_on      = 1'b1;
        burst_left     = 10;
        mismatch_count = 0;
        bytes_sent     = 0;
        reset_line_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_status_codes();
        test_checksum_text();
        test_dropped_bytes();
        test_line_limit();
        test_random_frames(180);
        test_back_pressure();
        test_random_frames(180);

        // Drain outstanding verdicts, then allow for pipeline latency
        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
